>>> rtl/etp_pkg.sv
`default_nettype none

package etp_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int WRAP_W     = 32;
    localparam int CNT_W      = 31;
    localparam int SLOT_IDX_W = 7;

    // defaults for the top level parameters
    localparam int SLOTS_PER_PACKET_DEF = 120;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // reset value of the edge count wrap limit
    localparam logic [CNT_W-1:0] COUNT_LIMIT_RESET = 31'h5FFF_FFFF;

    // edge event handed from the front end to the record builder
    typedef struct packed {
        logic              quad;
        logic [TIME_W-1:0] time_val;
        logic [WRAP_W-1:0] wraps;
    } t_evt;

endpackage

`default_nettype wire

>>> rtl/etp_if.sv
`default_nettype none

// sample channel
interface etp_in_if import etp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              encoder_level;
    logic              quad_level;
    logic [TIME_W-1:0] time_now;
    logic [WRAP_W-1:0] wrap_total;
    logic              wrap_pending;

    modport source (output valid, encoder_level, quad_level, time_now, wrap_total,
                    wrap_pending, input ready);
    modport sink   (input valid, encoder_level, quad_level, time_now, wrap_total,
                    wrap_pending, output ready);
endinterface

// capture record channel
interface etp_out_if import etp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  packet_select;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TIME_W-1:0]     edge_time;
    logic [WRAP_W-1:0]     edge_wraps;
    logic [CNT_W-1:0]      edge_number;
    logic                  quad_capture;
    logic                  packet_done;

    modport source (output valid, packet_select, slot_index, edge_time, edge_wraps,
                    edge_number, quad_capture, packet_done, input ready);
    modport sink   (input valid, packet_select, slot_index, edge_time, edge_wraps,
                    edge_number, quad_capture, packet_done, output ready);
endinterface

`default_nettype wire

>>> rtl/etp_front.sv
`default_nettype none

module etp_front import etp_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    etp_in_if.sink i_in,
    input  wire   i_q_full,
    output logic  o_push,
    output t_evt  o_evt
);

    logic r_prev;
    logic n_prev;
    logic w_accept;

    // take a sample whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;

    // either edge of the encoder line raises an event
    assign o_push = w_accept && (i_in.encoder_level != r_prev);

    assign o_evt.quad     = i_in.quad_level;
    assign o_evt.time_val = i_in.time_now;
    assign o_evt.wraps    = i_in.wrap_total + WRAP_W'(i_in.wrap_pending);

    always_comb begin
        n_prev = r_prev;
        if (w_accept) begin
            n_prev = i_in.encoder_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
        end else begin
            r_prev <= n_prev;
        end
    end

`ifndef SYNTHESIS
    // an event always leaves the stored level at the new one
    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_prev == $past(i_in.encoder_level)))
        else $error("front: stored level not updated on edge");
    // no event without a sample taken
    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_in.valid && !i_q_full))
        else $error("front: event without accepted sample");
`endif

endmodule

`default_nettype wire

>>> rtl/etp_queue.sv
`default_nettype none

module etp_queue import etp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_evt i_evt,
    input  wire  i_pop,
    output logic o_full,
    output logic o_valid,
    output t_evt o_evt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    t_evt              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_QW-1:0] n_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue: fill count beyond depth");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue: event pushed while full");
`endif

endmodule

`default_nettype wire

>>> rtl/etp_back.sv
`default_nettype none

module etp_back import etp_pkg::*; #(
    parameter int SLOTS_PER_PACKET = SLOTS_PER_PACKET_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [CNT_W-1:0] i_limit,
    input  wire              i_q_valid,
    input  t_evt             i_evt,
    output logic             o_pop,
    etp_out_if.source        o_out
);

    localparam int SLOT_W = (SLOTS_PER_PACKET > 1) ? $clog2(SLOTS_PER_PACKET) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_PACKET - 1);

    logic [CNT_W-1:0]  r_edge_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic              r_toggle;
    logic              r_out_valid;
    logic [CNT_W-1:0]  n_edge_cnt;
    logic [SLOT_W-1:0] n_slot;
    logic              n_toggle;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic              w_last;
    logic              w_load;

    // output register free or being emptied this cycle
    assign w_load = !r_out_valid || o_out.ready;
    assign o_pop  = i_q_valid && w_load;

    assign w_cnt_inc = r_edge_cnt + 1'b1;
    assign w_last    = (r_slot >= SLOT_LAST);

    // counter updates for one record
    always_comb begin
        n_edge_cnt = r_edge_cnt;
        n_slot     = r_slot;
        n_toggle   = r_toggle;
        if (o_pop) begin
            n_edge_cnt = (w_cnt_inc == i_limit) ? '0 : w_cnt_inc;
            if (w_last) begin
                n_slot   = '0;
                n_toggle = !r_toggle;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt  <= '0;
            r_slot      <= '0;
            r_toggle    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_edge_cnt <= n_edge_cnt;
            r_slot     <= n_slot;
            r_toggle   <= n_toggle;
            if (w_load) begin
                r_out_valid <= i_q_valid;
            end
        end
    end

    // record payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_out.packet_select <= r_toggle;
            o_out.slot_index    <= SLOT_IDX_W'(r_slot);
            o_out.edge_time     <= i_evt.time_val;
            o_out.edge_wraps    <= i_evt.wraps;
            o_out.edge_number   <= w_cnt_inc;
            o_out.quad_capture  <= (r_slot == '0) ? i_evt.quad : 1'b0;
            o_out.packet_done   <= w_last;
        end
    end

    assign o_out.valid = r_out_valid;

`ifndef SYNTHESIS
    a_done_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_last) |=> (r_slot == '0 && r_toggle != $past(r_toggle)))
        else $error("back: packet not switched after last slot");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("back: slot beyond packet");
`endif

endmodule

`default_nettype wire

>>> rtl/edge_timestamp_packetizer.sv
`default_nettype none

// Channel   Dir  Handshake     Content
// i_in      in   valid/ready   one line sample: levels, timer, wrap total and flag
// o_out     out  valid/ready   one capture record per encoder edge
// i_cfg_*   in   write enable  edge count wrap limit
//
// One sample is taken per cycle while the two-entry edge queue has room.
// A sample with an edge passes through a queue entry and then the output register before it shows on o_out.
// The record builder does one record a cycle while its output register is free or being emptied.
// Reset is synchronous, active low; limit returns to 0x5FFFFFFF, counters to zero.
// A stalled o_out fills the output register, then the queue, then drops i_in.ready.

module edge_timestamp_packetizer import etp_pkg::*; #(
    parameter int SLOTS_PER_PACKET = SLOTS_PER_PACKET_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    etp_in_if.sink           i_in,
    etp_out_if.source        o_out,
    input  wire              i_cfg_we,
    input  wire  [CNT_W-1:0] i_cfg_wdata
);

    logic [CNT_W-1:0] r_limit;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_valid;
    t_evt             w_evt_in;
    t_evt             w_evt_out;

    // wrap limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= COUNT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    etp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_evt    (w_evt_in)
    );

    etp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_evt   (w_evt_out)
    );

    etp_back #(
        .SLOTS_PER_PACKET (SLOTS_PER_PACKET)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_limit),
        .i_q_valid (w_q_valid),
        .i_evt     (w_evt_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
